FILE: hw/rtl/ttc_pkg.sv
`timescale 1ns / 1ps
package ttc_pkg;

  // Fixed point formats
  localparam int LOG_FRAC = 24;   // fraction bits of a log2 value
  localparam int MANT_W   = 31;   // Q1.30 mantissa
  localparam int KEL_W    = 26;   // Kelvin in Q10.16

  localparam logic [KEL_W-1:0] KELVIN_MAX = 26'h3FFFFFF;
  localparam logic [KEL_W-1:0] K298_Q16   = 26'd19539722;
  localparam logic [KEL_W-1:0] K273_Q16   = 26'd17901158;

  // Celsius output saturation limits
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Rounded-up reciprocals: floor(x / d) equals (x * RECIP) >> SH for every
  // numerator below 2^SH
  localparam logic [41:0] RECIP5     = 42'd54975581389;
  localparam int          RECIP5_SH  = 38;
  localparam logic [41:0] RECIP19    = 42'd1851809057307;
  localparam int          RECIP19_SH = 45;

  typedef enum logic [1:0] {
    CFG_PTAT   = 2'd0,
    CFG_SLOPE  = 2'd1,
    CFG_OFFSET = 2'd2,
    CFG_GAIN   = 2'd3
  } cfg_idx_t;

endpackage

FILE: hw/rtl/ttc_mlog.sv
`timescale 1ns / 1ps
module ttc_mlog #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [ttc_pkg::MANT_W-1:0]    in_m,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic [ttc_pkg::LOG_FRAC-1:0]  out_f,
  output logic [SW-1:0]                 out_side
);
  import ttc_pkg::*;

  logic                v  [0:LOG_FRAC];
  logic [MANT_W-1:0]   m  [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] f  [0:LOG_FRAC];
  logic [SW-1:0]       sd [0:LOG_FRAC];

  // Register the mantissa on entry
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      m[0]  <= in_m;
      f[0]  <= '0;
      sd[0] <= in_side;
    end
  end

  // One squaring per stage, one fraction bit out of each
  for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     mm;

    assign sq = m[i-1] * m[i-1];
    assign mm = sq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
      if (en) begin
        m[i]  <= mm[MANT_W] ? mm[MANT_W:1] : mm[MANT_W-1:0];
        f[i]  <= {f[i-1][LOG_FRAC-2:0], mm[MANT_W]};
        sd[i] <= sd[i-1];
      end
    end
  end

  assign out_valid = v[LOG_FRAC];
  assign out_f     = f[LOG_FRAC];
  assign out_side  = sd[LOG_FRAC];

endmodule

FILE: hw/rtl/ttc_udiv.sv
`timescale 1ns / 1ps
module ttc_udiv #(
  parameter int NW = 32,
  parameter int DW = 10,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  import ttc_pkg::*;

  logic          v  [0:NW-1];
  logic [DW-1:0] r  [0:NW-1];
  logic [NW-1:0] q  [0:NW-1];
  logic [DW-1:0] d  [0:NW-1];
  logic [SW-1:0] sd [0:NW-1];

  // Restoring division, one quotient bit per stage; the numerator shifts
  // out at the top while quotient bits shift in at the bottom
  for (genvar i = 0; i < NW; i++) begin : g_st
    logic          pv;
    logic [DW-1:0] pr;
    logic [NW-1:0] pq;
    logic [DW-1:0] pd;
    logic [SW-1:0] ps;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign pr = '0;
      assign pq = in_num;
      assign pd = in_den;
      assign ps = in_side;
    end else begin : g_next
      assign pv = v[i-1];
      assign pr = r[i-1];
      assign pq = q[i-1];
      assign pd = d[i-1];
      assign ps = sd[i-1];
    end

    assign trial = {pr, pq[NW-1]};
    assign diff  = trial - {1'b0, pd};
    assign ge    = trial >= {1'b0, pd};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= pv;
      end
      if (en) begin
        r[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q[i]  <= {pq[NW-2:0], ge};
        d[i]  <= pd;
        sd[i] <= ps;
      end
    end
  end

  assign out_valid = v[NW-1];
  assign out_quo   = q[NW-1];
  assign out_side  = sd[NW-1];

endmodule

// Divide by a constant: multiply by the rounded-up reciprocal RECIP and drop
// SH bits. The product comes from four partial products of at most 18 by 21
// bits, summed over two more stages.
module ttc_cdiv #(
  parameter int          NW    = 35,
  parameter logic [41:0] RECIP = 42'd1,
  parameter int          SH    = 0,
  parameter int          SW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [35:0]   xn;
  logic          va;
  logic          vb;
  logic [SW-1:0] sa;
  logic [SW-1:0] sb;
  logic [38:0]   pp_hh;
  logic [38:0]   pp_hl;
  logic [38:0]   pp_lh;
  logic [38:0]   pp_ll;
  logic [59:0]   s_hi;
  logic [59:0]   s_lo;
  logic [77:0]   tot;
  logic [77:0]   sc;

  assign xn = 36'(in_num);

  // Partial products of numerator and reciprocal halves
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      pp_hh <= xn[35:18] * RECIP[41:21];
      pp_hl <= xn[35:18] * RECIP[20:0];
      pp_lh <= xn[17:0] * RECIP[41:21];
      pp_ll <= xn[17:0] * RECIP[20:0];
      sa    <= in_side;
    end
  end

  // Combine into the two numerator-half products
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      s_hi <= (60'(pp_hh) << 21) + 60'(pp_hl);
      s_lo <= (60'(pp_lh) << 21) + 60'(pp_ll);
      sb   <= sa;
    end
  end

  // Final sum and shift
  assign tot = (78'(s_hi) << 18) + 78'(s_lo);
  assign sc  = tot >> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
    if (en) begin
      out_quo  <= sc[NW-1:0];
      out_side <= sb;
    end
  end

endmodule

FILE: hw/rtl/ttc_log2.sv
`timescale 1ns / 1ps
module ttc_log2 #(
  parameter int XW = 26,
  parameter int FB = 16,
  parameter int LW = 31,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [XW-1:0]        in_x,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [LW-1:0] out_lg,
  output logic [SW-1:0]        out_side
);
  import ttc_pkg::*;

  localparam int NW = $clog2(XW);
  localparam int IW = LW - LOG_FRAC;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [SW-1:0] sd;
  } lcarry_t;

  function automatic logic [NW-1:0] top_bit(input logic [XW-1:0] x);
    logic [NW-1:0] n;
    n = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) n = NW'(i);
    end
    return n;
  endfunction

  logic          va;
  logic [XW-1:0] xa;
  logic [NW-1:0] na;
  logic [SW-1:0] sa;

  // Find the leading one
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      xa <= in_x;
      na <= top_bit(in_x);
      sa <= in_side;
    end
  end

  // Normalize to a Q1.30 mantissa
  logic [63:0]       xw;
  logic [63:0]       xn;
  logic [MANT_W-1:0] mn;
  lcarry_t           cin;
  lcarry_t           cout;
  logic              mv;
  logic [LOG_FRAC-1:0] mf;
  logic [$bits(lcarry_t)-1:0] cout_bits;

  assign xw = 64'(xa);
  always_comb begin
    if (7'(na) >= 7'd30) xn = xw >> (7'(na) - 7'd30);
    else                 xn = xw << (7'd30 - 7'(na));
  end
  assign mn = xn[MANT_W-1:0];
  assign cin.n  = na;
  assign cin.sd = sa;

  ttc_mlog #(.SW($bits(lcarry_t))) u_mlog (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (va),
    .in_m     (mn),
    .in_side  (cin),
    .out_valid(mv),
    .out_f    (mf),
    .out_side (cout_bits)
  );
  assign cout = cout_bits;

  // Join integer part and fraction
  logic [IW-1:0] ip;
  assign ip = IW'(cout.n) - IW'(FB);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mv;
    end
    if (en) begin
      out_lg   <= {ip, mf};
      out_side <= cout.sd;
    end
  end

endmodule

FILE: hw/rtl/ttc_exp2.sv
`timescale 1ns / 1ps
module ttc_exp2 #(
  parameter int EW = 36,
  parameter int FB = 8,
  parameter int RW = 48,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [EW-1:0] in_e,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic [RW-1:0]        out_r,
  output logic [SW-1:0]        out_side
);
  import ttc_pkg::*;

  localparam int KW    = EW - LOG_FRAC;
  localparam int SH    = KW + 2;
  localparam int STEPS = MANT_W - 1;

  typedef struct packed {
    logic [MANT_W-1:0]   m;
    logic [LOG_FRAC-1:0] f;
    logic signed [KW-1:0] k;
    logic [SW-1:0]       sd;
  } ecarry_t;

  logic    vin [0:STEPS];
  ecarry_t cin [0:STEPS];

  assign vin[0]    = in_valid;
  assign cin[0].m  = MANT_W'(1) << (MANT_W - 1);
  assign cin[0].f  = in_e[LOG_FRAC-1:0];
  assign cin[0].k  = in_e[EW-1:LOG_FRAC];
  assign cin[0].sd = in_side;

  // Build the mantissa bit by bit from the top: keep a bit while its
  // log2 fraction stays at or below the target fraction
  for (genvar j = 0; j < STEPS; j++) begin : g_bit
    localparam logic [MANT_W-1:0] BIT = MANT_W'(1) << (STEPS - 1 - j);
    logic                  ov;
    logic [LOG_FRAC-1:0]   ofl;
    logic [$bits(ecarry_t)-1:0] obits;
    ecarry_t               co;
    ecarry_t               nxt;

    ttc_mlog #(.SW($bits(ecarry_t))) u_mlog (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (vin[j]),
      .in_m     (cin[j].m | BIT),
      .in_side  (cin[j]),
      .out_valid(ov),
      .out_f    (ofl),
      .out_side (obits)
    );
    assign co = obits;

    always_comb begin
      nxt = co;
      if (ofl <= co.f) nxt.m = co.m | BIT;
    end

    assign vin[j+1] = ov;
    assign cin[j+1] = nxt;
  end

  // Scale the mantissa by the integer exponent
  logic signed [SH-1:0] s;
  logic [63:0]          wide;
  logic [63:0]          res;
  logic [6:0]           amt;

  assign s    = SH'(cin[STEPS].k) + SH'(FB - 30);
  assign wide = 64'(cin[STEPS].m);

  always_comb begin
    amt = '0;
    res = '0;
    if (!s[SH-1]) begin
      amt = (s > SH'(32)) ? 7'd32 : 7'(s);
      res = wide << amt;
    end else if (s > SH'(-64)) begin
      amt = 7'(-s);
      res = wide >> amt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vin[STEPS];
    end
    if (en) begin
      out_r    <= res[RW-1:0];
      out_side <= cin[STEPS].sd;
    end
  end

endmodule

FILE: hw/rtl/thermopile_temperature_conversion_core.sv
`timescale 1ns / 1ps
// Thermopile temperature conversion. Each item carries one raw ambient and
// one raw object count and yields ambient and object temperature in Celsius
// (signed, OUT_FRAC_BITS fraction bits, saturated) plus a flag for a negative
// radiance sum, in which case the object temperature reads zero. The core is
// a fully pipelined datapath: it takes one item per clock while the result
// side is not stalled. Most of the pipeline lies in the two exp2 units, each
// a chain of 30 mantissa bit decisions, and every decision a 25-stage
// squaring pipeline. A stall on the result side freezes the whole pipeline,
// so nothing is dropped. Calibration registers are written through the cfg
// port and must only change while no item is in flight.
module thermopile_temperature_conversion_core #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [14:0] raw_ambient, [31:15] raw_object
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [17:0] object_celsius, [35:18] ambient_celsius,
                                 // [36] object_invalid, [39:37] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ttc_pkg::*;

  localparam int SHR = 16 - OUT_FRAC_BITS;

  typedef struct packed {
    logic              a_neg;
    logic signed [49:0] prod;
  } side_a_t;

  typedef struct packed {
    logic [KEL_W-1:0]  ka;
    logic signed [49:0] prod;
  } side_b_t;

  typedef struct packed {
    logic    neg;
    side_b_t b;
  } side_c_t;

  typedef struct packed {
    logic [KEL_W-1:0] ka;
    logic             b_neg;
    logic             b_zero;
  } side_d_t;

  typedef struct packed {
    logic    neg;
    side_d_t d;
  } side_e_t;

  function automatic logic [17:0] to_celsius(input logic [KEL_W-1:0] k);
    logic signed [27:0] c;
    logic signed [27:0] t;
    logic signed [27:0] q;
    c = $signed({2'b00, k}) - $signed({2'b00, K273_Q16});
    t = c + 28'(1 << (SHR - 1));
    q = t >>> SHR;
    if (q > 28'(OUT_MAX))      return 18'(OUT_MAX);
    else if (q < 28'(OUT_MIN)) return 18'(OUT_MIN);
    else                       return q[17:0];
  endfunction

  // Calibration registers
  logic [15:0] ptat;
  logic [9:0]  slope;
  logic [16:0] offset;
  logic [31:0] gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptat   <= '0;
      slope  <= 10'd1;
      offset <= 17'd32768;
      gain   <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PTAT:   ptat   <= cfg_data[15:0];
        CFG_SLOPE:  slope  <= cfg_data[9:0];
        CFG_OFFSET: offset <= cfg_data[16:0];
        CFG_GAIN:   gain   <= cfg_data;
        default:    ptat   <= ptat;
      endcase
    end
  end

  // Global advance: hold everything while a result waits
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: differences and radiance partial products
  logic signed [17:0] a_diff;
  logic signed [17:0] o_diff;
  logic signed [34:0] pp_lo_c;
  logic signed [34:0] pp_hi_c;

  assign a_diff  = $signed({3'b000, s_tdata[14:0]}) - $signed({2'b00, ptat});
  assign o_diff  = $signed({1'b0, s_tdata[31:15]}) - $signed({1'b0, offset});
  assign pp_lo_c = o_diff * $signed({1'b0, gain[15:0]});
  assign pp_hi_c = o_diff * $signed({1'b0, gain[31:16]});

  logic               t1_v;
  logic               t1_neg;
  logic [15:0]        t1_mag;
  logic [9:0]         t1_den;
  logic signed [34:0] t1_lo;
  logic signed [34:0] t1_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (en) begin
      t1_v <= s_tvalid;
    end
    if (en) begin
      t1_neg <= a_diff[17];
      t1_mag <= a_diff[17] ? 16'(-a_diff) : a_diff[15:0];
      t1_den <= (slope == '0) ? 10'd1 : slope;
      t1_lo  <= pp_lo_c;
      t1_hi  <= pp_hi_c;
    end
  end

  // Ambient division
  side_a_t            sa_in;
  side_a_t            sa_out;
  logic signed [50:0] prod_w;
  logic               d1_v;
  logic [31:0]        d1_q;
  logic [$bits(side_a_t)-1:0] sa_bits;

  assign prod_w       = (51'(t1_hi) <<< 16) + 51'(t1_lo);
  assign sa_in.a_neg  = t1_neg;
  assign sa_in.prod   = prod_w[49:0];

  ttc_udiv #(.NW(32), .DW(10), .SW($bits(side_a_t))) u_div_amb (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t1_v),
    .in_num   ({t1_mag, 16'h0000}),
    .in_den   (t1_den),
    .in_side  (sa_in),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_side (sa_bits)
  );
  assign sa_out = sa_bits;

  // Stage 3: ambient Kelvin, clamped
  logic [33:0]      ksum;
  logic [KEL_W-1:0] ka_c;
  logic             t3_v;
  side_b_t          t3;

  assign ksum = sa_out.a_neg ? 34'(K298_Q16) - 34'(d1_q) : 34'(K298_Q16) + 34'(d1_q);
  always_comb begin
    if (ksum[33])                   ka_c = '0;
    else if (ksum > 34'(KELVIN_MAX)) ka_c = KELVIN_MAX;
    else                             ka_c = ksum[KEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_v <= 1'b0;
    end else if (en) begin
      t3_v <= d1_v;
    end
    if (en) begin
      t3.ka   <= ka_c;
      t3.prod <= sa_out.prod;
    end
  end

  // log2 of ambient Kelvin
  logic               l1_v;
  logic signed [30:0] l1_lg;
  side_b_t            l1_s;
  logic [$bits(side_b_t)-1:0] l1_bits;

  ttc_log2 #(.XW(KEL_W), .FB(16), .LW(31), .SW($bits(side_b_t))) u_log_amb (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t3_v),
    .in_x     (t3.ka),
    .in_side  (t3),
    .out_valid(l1_v),
    .out_lg   (l1_lg),
    .out_side (l1_bits)
  );
  assign l1_s = l1_bits;

  // Stage 4: times 19, magnitude form
  logic [30:0] l1_mag;
  logic        t4_v;
  logic [34:0] t4_num;
  side_c_t     t4;

  assign l1_mag = l1_lg[30] ? 31'(-l1_lg) : 31'(l1_lg);

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_v <= 1'b0;
    end else if (en) begin
      t4_v <= l1_v;
    end
    if (en) begin
      t4_num <= (35'(l1_mag) << 4) + (35'(l1_mag) << 1) + 35'(l1_mag);
      t4.neg <= l1_lg[30];
      t4.b   <= l1_s;
    end
  end

  // Divide by 5
  logic        d2_v;
  logic [34:0] d2_q;
  side_c_t     d2_s;
  logic [$bits(side_c_t)-1:0] d2_bits;

  ttc_cdiv #(.NW(35), .RECIP(RECIP5), .SH(RECIP5_SH), .SW($bits(side_c_t))) u_div5 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t4_v),
    .in_num   (t4_num),
    .in_side  (t4),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_side (d2_bits)
  );
  assign d2_s = d2_bits;

  // Stage 5: restore sign of the exponent
  logic               t5_v;
  logic signed [35:0] t5_e;
  side_b_t            t5;

  always_ff @(posedge clk) begin
    if (rst) begin
      t5_v <= 1'b0;
    end else if (en) begin
      t5_v <= d2_v;
    end
    if (en) begin
      t5_e <= d2_s.neg ? -$signed(36'(d2_q)) : $signed(36'(d2_q));
      t5   <= d2_s.b;
    end
  end

  // Ambient radiance term
  logic        x1_v;
  logic [47:0] x1_p;
  side_b_t     x1_s;
  logic [$bits(side_b_t)-1:0] x1_bits;

  ttc_exp2 #(.EW(36), .FB(8), .RW(48), .SW($bits(side_b_t))) u_exp_amb (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t5_v),
    .in_e     (t5_e),
    .in_side  (t5),
    .out_valid(x1_v),
    .out_r    (x1_p),
    .out_side (x1_bits)
  );
  assign x1_s = x1_bits;

  // Stage 6: radiance sum
  logic [47:0]        pz;
  logic signed [50:0] bsum;
  logic               t6_v;
  logic [49:0]        t6_b;
  side_d_t            t6;

  assign pz   = (x1_s.ka == '0) ? '0 : x1_p;
  assign bsum = $signed({3'b000, pz}) + 51'(x1_s.prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      t6_v <= 1'b0;
    end else if (en) begin
      t6_v <= x1_v;
    end
    if (en) begin
      t6_b      <= bsum[49:0];
      t6.ka     <= x1_s.ka;
      t6.b_neg  <= bsum[50];
      t6.b_zero <= (bsum == '0);
    end
  end

  // log2 of the radiance sum
  logic               l2_v;
  logic signed [30:0] l2_lg;
  side_d_t            l2_s;
  logic [$bits(side_d_t)-1:0] l2_bits;

  ttc_log2 #(.XW(50), .FB(8), .LW(31), .SW($bits(side_d_t))) u_log_obj (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t6_v),
    .in_x     (t6_b),
    .in_side  (t6),
    .out_valid(l2_v),
    .out_lg   (l2_lg),
    .out_side (l2_bits)
  );
  assign l2_s = l2_bits;

  // Stage 7: times 5, magnitude form
  logic [30:0] l2_mag;
  logic        t7_v;
  logic [33:0] t7_num;
  side_e_t     t7;

  assign l2_mag = l2_lg[30] ? 31'(-l2_lg) : 31'(l2_lg);

  always_ff @(posedge clk) begin
    if (rst) begin
      t7_v <= 1'b0;
    end else if (en) begin
      t7_v <= l2_v;
    end
    if (en) begin
      t7_num <= (34'(l2_mag) << 2) + 34'(l2_mag);
      t7.neg <= l2_lg[30];
      t7.d   <= l2_s;
    end
  end

  // Divide by 19
  logic        d3_v;
  logic [33:0] d3_q;
  side_e_t     d3_s;
  logic [$bits(side_e_t)-1:0] d3_bits;

  ttc_cdiv #(.NW(34), .RECIP(RECIP19), .SH(RECIP19_SH), .SW($bits(side_e_t))) u_div19 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t7_v),
    .in_num   (t7_num),
    .in_side  (t7),
    .out_valid(d3_v),
    .out_quo  (d3_q),
    .out_side (d3_bits)
  );
  assign d3_s = d3_bits;

  // Stage 8: restore sign of the exponent
  logic               t8_v;
  logic signed [34:0] t8_e;
  side_d_t            t8;

  always_ff @(posedge clk) begin
    if (rst) begin
      t8_v <= 1'b0;
    end else if (en) begin
      t8_v <= d3_v;
    end
    if (en) begin
      t8_e <= d3_s.neg ? -$signed(35'(d3_q)) : $signed(35'(d3_q));
      t8   <= d3_s.d;
    end
  end

  // Object Kelvin
  logic        x2_v;
  logic [31:0] x2_k;
  side_d_t     x2_s;
  logic [$bits(side_d_t)-1:0] x2_bits;

  ttc_exp2 #(.EW(35), .FB(16), .RW(32), .SW($bits(side_d_t))) u_exp_obj (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (t8_v),
    .in_e     (t8_e),
    .in_side  (t8),
    .out_valid(x2_v),
    .out_r    (x2_k),
    .out_side (x2_bits)
  );
  assign x2_s = x2_bits;

  // Final: clamp, convert to Celsius, drive the output register
  logic [KEL_W-1:0] ko;
  logic [17:0]      obj_c;
  logic [17:0]      amb_c;

  always_comb begin
    if (x2_s.b_zero)                   ko = '0;
    else if (x2_k > 32'(KELVIN_MAX))   ko = KELVIN_MAX;
    else                               ko = x2_k[KEL_W-1:0];
  end
  assign obj_c = x2_s.b_neg ? '0 : to_celsius(ko);
  assign amb_c = to_celsius(x2_s.ka);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= x2_v;
    end
    if (en) begin
      m_tdata <= {3'b000, x2_s.b_neg, amb_c, obj_c};
    end
  end

endmodule
